// ===== src/ipdhp_pkg.sv =====
// ipdhp_pkg: shared types and constants for the ipd request header parser
// holds the transfer payload structs, the parse step enum and the header literal
// no dependencies
package ipdhp_pkg;

  // character codes used by the header grammar
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_I     = 8'h49;  // 'I'
  localparam logic [7:0] CH_P     = 8'h50;  // 'P'
  localparam logic [7:0] CH_D     = 8'h44;  // 'D'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [15:0] ASCII_ZERO = 16'd48;

  // parse position
  typedef enum logic [3:0] {
    ST_PLUS    = 4'd0,
    ST_I       = 4'd1,
    ST_P       = 4'd2,
    ST_D       = 4'd3,
    ST_COMMA   = 4'd4,
    ST_CHANNEL = 4'd5,
    ST_LENGTH  = 4'd6,
    ST_METHOD  = 4'd7,
    ST_ROUTE   = 4'd8,
    ST_DONE    = 4'd9
  } step_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_window;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  route_byte;
    logic [15:0] channel;
    logic        request_done;
  } out_item_t;

  // expected character of the "+IPD," literal at a header step
  function automatic logic [7:0] header_char(input step_t step);
    logic [7:0] ch;
    case (step)
      ST_PLUS: ch = CH_PLUS;
      ST_I:    ch = CH_I;
      ST_P:    ch = CH_P;
      ST_D:    ch = CH_D;
      default: ch = CH_COMMA;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/ipdhp_in_reg.sv =====
// ipdhp_in_reg: input register stage of the ipd request header parser
// captures one byte transfer and holds it until the parse stage takes it
// depends on ipdhp_pkg
module ipdhp_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ipdhp_pkg::in_item_t  in_item,
  output logic                 held_valid,
  output ipdhp_pkg::in_item_t  held_item,
  input  logic                 take
);

  // room when empty or when the held byte leaves this cycle
  assign in_ready = !held_valid || take;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== src/ipdhp_fsm.sv =====
// ipdhp_fsm: parse state machine and channel accumulator
// consumes one held byte per cycle (a route byte needs a free output slot)
// forms the result item for route bytes; depends on ipdhp_pkg
module ipdhp_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 held_valid,
  input  ipdhp_pkg::in_item_t  held_item,
  input  logic                 out_free,
  output logic                 take,
  output logic                 res_valid,
  output ipdhp_pkg::out_item_t res_item
);

  ipdhp_pkg::step_t step;
  ipdhp_pkg::step_t step_next;
  logic [15:0]      channel_accum;
  logic [15:0]      channel_accum_next;

  ipdhp_pkg::step_t eff_step;
  logic [15:0]      eff_accum;
  logic [15:0]      accum_x10;
  logic [7:0]       c;
  logic             emits;

  // a new window restarts the parse before this byte
  assign c         = held_item.rx_byte;
  assign eff_step  = held_item.new_window ? ipdhp_pkg::ST_PLUS : step;
  assign eff_accum = held_item.new_window ? 16'd0 : channel_accum;
  assign accum_x10 = (eff_accum << 3) + (eff_accum << 1);

  // only route bytes need the output slot
  assign emits     = (eff_step == ipdhp_pkg::ST_ROUTE);
  assign take      = held_valid && (!emits || out_free);
  assign res_valid = take && emits;

  always_comb begin
    res_item.route_byte   = (c == ipdhp_pkg::CH_SPACE) ? 8'd0 : c;
    res_item.channel      = eff_accum;
    res_item.request_done = (c == ipdhp_pkg::CH_SPACE);
  end

  // next state and accumulator
  always_comb begin
    step_next          = eff_step;
    channel_accum_next = eff_accum;
    case (eff_step)
      ipdhp_pkg::ST_PLUS, ipdhp_pkg::ST_I, ipdhp_pkg::ST_P, ipdhp_pkg::ST_D,
      ipdhp_pkg::ST_COMMA: begin
        if (c == ipdhp_pkg::header_char(eff_step)) begin
          step_next = ipdhp_pkg::step_t'(eff_step + 4'd1);
          if (eff_step == ipdhp_pkg::ST_COMMA) begin
            channel_accum_next = 16'd0;
          end
        end else begin
          step_next = ipdhp_pkg::ST_PLUS;
        end
      end
      ipdhp_pkg::ST_CHANNEL: begin
        if (c == ipdhp_pkg::CH_COMMA) begin
          step_next = ipdhp_pkg::ST_LENGTH;
        end else begin
          channel_accum_next = accum_x10 + {8'd0, c} - ipdhp_pkg::ASCII_ZERO;
        end
      end
      ipdhp_pkg::ST_LENGTH: begin
        if (c == ipdhp_pkg::CH_COLON) begin
          step_next = ipdhp_pkg::ST_METHOD;
        end
      end
      ipdhp_pkg::ST_METHOD: begin
        if (c == ipdhp_pkg::CH_SPACE) begin
          step_next = ipdhp_pkg::ST_ROUTE;
        end
      end
      ipdhp_pkg::ST_ROUTE: begin
        if (c == ipdhp_pkg::CH_SPACE) begin
          step_next = ipdhp_pkg::ST_DONE;
        end
      end
      ipdhp_pkg::ST_DONE: begin
        step_next = ipdhp_pkg::ST_DONE;
      end
      default: begin
        step_next = ipdhp_pkg::ST_PLUS;
      end
    endcase
  end

  // state registers advance when the held byte is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= ipdhp_pkg::ST_PLUS;
      channel_accum <= 16'd0;
    end else if (take) begin
      step          <= step_next;
      channel_accum <= channel_accum_next;
    end
  end

endmodule

// ===== src/ipdhp_out_reg.sv =====
// ipdhp_out_reg: result register of the ipd request header parser
// holds one result until the downstream transfer completes
// depends on ipdhp_pkg
module ipdhp_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  input  ipdhp_pkg::out_item_t  res_item,
  output logic                  out_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ipdhp_pkg::out_item_t  out_item
);

  // slot frees when empty or drained this cycle
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_item <= res_item;
    end
  end

endmodule

// ===== src/ipd_request_header_parser.sv =====
// ipd_request_header_parser: input register, parse stage and result register in order;
// throughput one byte per cycle unless a route byte waits on a stalled result,
// set by the single parse stage between two registers
// an input transfer is taken while a result waits, as long as that byte gives no result
// reset (rst, synchronous) empties both registers and returns the parse to idle
// depends on ipdhp_pkg, ipdhp_in_reg, ipdhp_fsm, ipdhp_out_reg
module ipd_request_header_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ipdhp_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ipdhp_pkg::out_item_t  out_item
);

  logic                 held_valid;
  ipdhp_pkg::in_item_t  held_item;
  logic                 take;
  logic                 out_free;
  logic                 res_valid;
  ipdhp_pkg::out_item_t res_item;

  ipdhp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  ipdhp_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_item  (held_item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res_item   (res_item)
  );

  ipdhp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_item  (res_item),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== src/ipdhp_checker.sv =====
// ipdhp_checker: port-level assertions for the ipd request header parser
// bound to ipd_request_header_parser; depends on ipdhp_pkg
module ipdhp_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input ipdhp_pkg::in_item_t   in_item,
  input logic                  out_valid,
  input logic                  out_ready,
  input ipdhp_pkg::out_item_t  out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // completion item carries a zero route byte
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.request_done |-> out_item.route_byte == 8'd0)
    else $error("completion item with nonzero route byte");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a draining output never stalls the input
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind ipd_request_header_parser ipdhp_checker u_ipdhp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
